// File: hdl/rtdr_pkg.sv
// rtdr_pkg: shared types, codes and reset constants of the rain threshold debounce reporter
// no dependencies
package rtdr_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int TIME_BITS_DEFAULT   = 32;

   localparam int THRESH_BITS    = 10;
   localparam int HOLD_BITS      = 8;
   localparam int MODE_BITS      = 2;
   localparam int PERIOD_BITS    = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [THRESH_BITS-1:0] RAIN_THRESHOLD_RESET = THRESH_BITS'(750);
   localparam logic [HOLD_BITS-1:0]   HOLD_POLLS_RESET     = HOLD_BITS'(50);
   localparam logic [PERIOD_BITS-1:0] REPORT_PERIOD_RESET  = PERIOD_BITS'(100);
   localparam logic [PERIOD_BITS-1:0] OFFLINE_PERIOD_RESET = PERIOD_BITS'(100);
   localparam logic [PERIOD_BITS-1:0] MIN_REPORT_PERIOD    = PERIOD_BITS'(10);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RAIN_THRESHOLD    = 3'd0,
      REG_HOLD_POLLS        = 3'd1,
      REG_REPORT_MODE       = 3'd2,
      REG_REPORT_PERIOD_MS  = 3'd3,
      REG_IS_ONLINE         = 3'd4,
      REG_OFFLINE_PERIOD_MS = 3'd5
   } reg_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ON_CHANGE = 2'd0,
      MODE_PERIODIC  = 2'd1,
      MODE_SILENT    = 2'd2
   } report_mode_type;

   localparam logic OP_POLL   = 1'b0;
   localparam logic OP_READ   = 1'b1;
   localparam logic DEST_HOST = 1'b0;
   localparam logic DEST_PEER = 1'b1;

   typedef struct packed {
      logic [THRESH_BITS-1:0] rain_threshold;
      logic [HOLD_BITS-1:0]   hold_polls;
      logic [MODE_BITS-1:0]   report_mode;
      logic [PERIOD_BITS-1:0] report_period_ms;
      logic                   is_online;
      logic [PERIOD_BITS-1:0] offline_period_ms;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic rain_detected;
      logic destination;
   } result_type;

endpackage

// File: hdl/rtdr_csr.sv
// rtdr_csr: configuration registers with write port and report period floor
// depends on rtdr_pkg
module rtdr_csr
   import rtdr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [PERIOD_BITS-1:0] period_wr;

   always_comb begin
      period_wr = csr_wdata[PERIOD_BITS-1:0];
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_RAIN_THRESHOLD:    cfg_in.rain_threshold = csr_wdata[THRESH_BITS-1:0];
            REG_HOLD_POLLS:        cfg_in.hold_polls = csr_wdata[HOLD_BITS-1:0];
            REG_REPORT_MODE:       cfg_in.report_mode = csr_wdata[MODE_BITS-1:0];
            REG_REPORT_PERIOD_MS:  cfg_in.report_period_ms =
               (period_wr < MIN_REPORT_PERIOD) ? MIN_REPORT_PERIOD : period_wr;
            REG_IS_ONLINE:         cfg_in.is_online = csr_wdata[0];
            REG_OFFLINE_PERIOD_MS: cfg_in.offline_period_ms = csr_wdata[PERIOD_BITS-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rain_threshold    <= RAIN_THRESHOLD_RESET;
         cfg_ff.hold_polls        <= HOLD_POLLS_RESET;
         cfg_ff.report_mode       <= MODE_ON_CHANGE;
         cfg_ff.report_period_ms  <= REPORT_PERIOD_RESET;
         cfg_ff.is_online         <= 1'b0;
         cfg_ff.offline_period_ms <= OFFLINE_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/rtdr_engine.sv
// rtdr_engine: threshold compare, debounce counter and report scheduling state
// depends on rtdr_pkg
module rtdr_engine
   import rtdr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = TIME_BITS_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   go,
   input  logic                   op,
   input  logic [SAMPLE_BITS-1:0] raw_sample,
   input  logic [TIME_BITS-1:0]   now_ms,
   output result_type             result
);

   localparam int SCMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int TCMP_BITS = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

   logic                 candidate_ff, candidate_in;
   logic [HOLD_BITS-1:0] hold_count_ff, hold_count_in;
   logic                 debounced_ff, debounced_in;
   logic                 last_rep_ff, last_rep_in;
   logic [TIME_BITS-1:0] online_mark_ff, online_mark_in;
   logic [TIME_BITS-1:0] offline_mark_ff, offline_mark_in;

   logic [SAMPLE_BITS-1:0] inverted;
   logic                   flag;
   logic                   cand_mid;
   logic [HOLD_BITS-1:0]   hold_mid;
   logic [TIME_BITS-1:0]   online_elapsed;
   logic [TIME_BITS-1:0]   offline_elapsed;
   logic                   online_due;
   logic                   offline_due;
   result_type             res;

   always_comb begin
      inverted = ~raw_sample;
      flag = SCMP_BITS'(inverted) > SCMP_BITS'(cfg.rain_threshold);
      cand_mid = (hold_count_ff == '0) ? flag : candidate_ff;
      hold_mid = (cand_mid == flag) ? hold_count_ff + HOLD_BITS'(1) : '0;

      candidate_in = cand_mid;
      hold_count_in = hold_mid;
      debounced_in = debounced_ff;
      if (hold_mid > cfg.hold_polls) begin
         debounced_in = cand_mid;
         hold_count_in = '0;
      end

      online_elapsed = now_ms - online_mark_ff;
      offline_elapsed = now_ms - offline_mark_ff;
      online_due = TCMP_BITS'(online_elapsed) > TCMP_BITS'(cfg.report_period_ms);
      offline_due = TCMP_BITS'(offline_elapsed) > TCMP_BITS'(cfg.offline_period_ms);

      last_rep_in = last_rep_ff;
      online_mark_in = online_mark_ff;
      offline_mark_in = offline_mark_ff;
      res.valid = 1'b0;
      res.rain_detected = debounced_in;
      res.destination = DEST_HOST;

      if (cfg.is_online) begin
         if (cfg.report_mode == MODE_PERIODIC) begin
            if (online_due) begin
               online_mark_in = now_ms;
               res.valid = 1'b1;
            end
         end else if (cfg.report_mode == MODE_ON_CHANGE) begin
            if (debounced_in != last_rep_ff) begin
               last_rep_in = debounced_in;
               res.valid = 1'b1;
            end
         end
      end else if (offline_due) begin
         offline_mark_in = now_ms;
         res.valid = 1'b1;
         res.destination = DEST_PEER;
      end

      if (op == OP_READ) begin
         res.valid = 1'b1;
         res.rain_detected = debounced_ff;
         res.destination = DEST_HOST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff    <= 1'b0;
         hold_count_ff   <= '0;
         debounced_ff    <= 1'b0;
         last_rep_ff     <= 1'b0;
         online_mark_ff  <= '0;
         offline_mark_ff <= '0;
      end else if (go && op == OP_POLL) begin
         candidate_ff    <= candidate_in;
         hold_count_ff   <= hold_count_in;
         debounced_ff    <= debounced_in;
         last_rep_ff     <= last_rep_in;
         online_mark_ff  <= online_mark_in;
         offline_mark_ff <= offline_mark_in;
      end
   end

   assign result = res;

endmodule

// File: hdl/rain_threshold_debounce_reporter_core.sv
// rain_threshold_debounce_reporter_core: top level with input word register and result register
// depends on rtdr_pkg, rtdr_csr, rtdr_engine
//
// channel   direction  tdata                          tuser
// req       in         raw_sample, now_ms (padded)    op
// rsp       out        rain_detected (padded)         destination
// csr       in         write only: csr_wen, csr_index, csr_wdata
//
// one word per clock while rsp does not stall; a poll is decided from the input
// register through the debounce and timer compare into the result register
// reset is synchronous; valid flags, configuration and engine state return to their reset values
// rsp stall holds the result register; req stays ready while the input register is empty or the result can move on
module rain_threshold_debounce_reporter_core
   import rtdr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = TIME_BITS_DEFAULT
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // raw_sample, now_ms, zero pad
   input  logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // op
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // rain_detected, zero pad
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // destination
   output logic                      rsp_tuser,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic                   in_valid_ff;
   logic                   in_op_ff;
   logic [SAMPLE_BITS-1:0] in_raw_ff;
   logic [TIME_BITS-1:0]   in_now_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_rain_ff;
   logic                   rsp_dest_ff;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   rtdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtdr_engine #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .go         (advance),
      .op         (in_op_ff),
      .raw_sample (in_raw_ff),
      .now_ms     (in_now_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_tuser;
         in_raw_ff <= req_tdata[SAMPLE_BITS-1:0];
         in_now_ff <= req_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_rain_ff <= result.rain_detected;
         rsp_dest_ff <= result.destination;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-1){1'b0}}, rsp_rain_ff};
   assign rsp_tuser  = rsp_dest_ff;

endmodule

// File: tb/sv/rain_report_checker.sv
`timescale 1ns / 1ps
// rain_report_checker: watches the req, rsp and csr ports of the rain reporter core, keeps
// its own registers, debounce state and report timers, and compares every rsp word
// depends on rtdr_pkg
module rain_report_checker
   import rtdr_pkg::*;
#(
   parameter int REQ_BITS = 48
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_BITS-1:0]       req_tdata,
   input  logic                      req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      rsp_tuser,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatches,
   output int                        owed
);
   localparam int SB = SAMPLE_BITS_DEFAULT;
   localparam int TB = TIME_BITS_DEFAULT;

   typedef struct packed {
      logic rain_detected;
      logic destination;
   } report_type;

   report_type owed_reports[$];
   cfg_type regs;
   logic cand_wet;
   logic [HOLD_BITS-1:0] streak;
   logic settled_wet;
   logic last_told;
   logic [TB-1:0] host_mark;
   logic [TB-1:0] peer_mark;
   int fails = 0;

   task automatic forecast(input logic op, input logic [SB-1:0] raw, input logic [TB-1:0] now);
      logic [SB-1:0] wetness;
      logic wet;
      logic [TB-1:0] gone;
      if (op == OP_READ) begin
         owed_reports.push_back(report_type'{settled_wet, DEST_HOST});
      end else begin
         wetness = {SB{1'b1}} - raw;
         wet = (wetness > regs.rain_threshold);
         if (streak == '0) cand_wet = wet;
         if (cand_wet == wet) streak = streak + HOLD_BITS'(1);
         else streak = '0;
         if (streak > regs.hold_polls) begin
            settled_wet = cand_wet;
            streak = '0;
         end
         if (!regs.is_online) begin
            gone = now - peer_mark;
            if (gone > regs.offline_period_ms) begin
               peer_mark = now;
               owed_reports.push_back(report_type'{settled_wet, DEST_PEER});
            end
         end else if (regs.report_mode == MODE_PERIODIC) begin
            gone = now - host_mark;
            if (gone > regs.report_period_ms) begin
               host_mark = now;
               owed_reports.push_back(report_type'{settled_wet, DEST_HOST});
            end
         end else if (regs.report_mode == MODE_ON_CHANGE && settled_wet != last_told) begin
            last_told = settled_wet;
            owed_reports.push_back(report_type'{settled_wet, DEST_HOST});
         end
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         regs.rain_threshold = RAIN_THRESHOLD_RESET;
         regs.hold_polls = HOLD_POLLS_RESET;
         regs.report_mode = MODE_ON_CHANGE;
         regs.report_period_ms = REPORT_PERIOD_RESET;
         regs.is_online = 1'b0;
         regs.offline_period_ms = OFFLINE_PERIOD_RESET;
         cand_wet = 1'b0;
         streak = '0;
         settled_wet = 1'b0;
         last_told = 1'b0;
         host_mark = '0;
         peer_mark = '0;
         owed_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_reports.size() == 0) begin
               fails++;
               $error("rsp word with no report owed: rain_detected %0b destination %0b",
                      rsp_tdata[0], rsp_tuser);
            end else begin
               want = owed_reports.pop_front();
               if (rsp_tdata[0] !== want.rain_detected) begin
                  fails++;
                  $error("rain_detected: expected %0b, actual %0b",
                         want.rain_detected, rsp_tdata[0]);
               end
               if (rsp_tuser !== want.destination) begin
                  fails++;
                  $error("destination: expected %0b, actual %0b", want.destination, rsp_tuser);
               end
               if (rsp_tdata[RSP_DATA_BITS-1:1] !== '0) begin
                  fails++;
                  $error("rsp_tdata pad: expected 0, actual %0h", rsp_tdata[RSP_DATA_BITS-1:1]);
               end
            end
         end
         if (csr_wen) begin
            case (csr_index)
               REG_RAIN_THRESHOLD:    regs.rain_threshold = csr_wdata[THRESH_BITS-1:0];
               REG_HOLD_POLLS:        regs.hold_polls = csr_wdata[HOLD_BITS-1:0];
               REG_REPORT_MODE:       regs.report_mode = csr_wdata[MODE_BITS-1:0];
               REG_REPORT_PERIOD_MS:  regs.report_period_ms =
                  (csr_wdata < MIN_REPORT_PERIOD) ? MIN_REPORT_PERIOD : csr_wdata;
               REG_IS_ONLINE:         regs.is_online = csr_wdata[0];
               REG_OFFLINE_PERIOD_MS: regs.offline_period_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            forecast(req_tuser, req_tdata[SB-1:0], req_tdata[SB+TB-1:SB]);
         end
      end
      mismatches = fails;
      owed = owed_reports.size();
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: clock, reset, register settings and poll/read stimulus for the rain reporter core
// depends on rtdr_pkg, rain_threshold_debounce_reporter_core and rain_report_checker
module tb;
   import rtdr_pkg::*;

   localparam int REQ_BITS = ((SAMPLE_BITS_DEFAULT + TIME_BITS_DEFAULT + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam logic [THRESH_BITS-1:0] SAMPLE_FULL = {THRESH_BITS{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // raw_sample, now_ms, zero pad
   logic [REQ_BITS-1:0] req_tdata = '0;
   // op
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // rain_detected, zero pad
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // destination
   logic rsp_tuser;
   logic csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatches;
   int owed;
   int cycle_count = 0;
   int hold_off = 0;
   int items_sent = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   logic [TIME_BITS_DEFAULT-1:0] wall_ms = '0;
   cfg_type plan;

   rain_threshold_debounce_reporter_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rain_report_checker #(.REQ_BITS(REQ_BITS)) report_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .owed(owed)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_len(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] dirty(input logic [CSR_DATA_BITS-1:0] v,
                                                     input int w);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = $urandom_range(0, 1) ? (CSR_DATA_BITS'($urandom) << w) : '0;
      return junk | v;
   endfunction

   // result side stalls
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off = hold_off - 1;
      end else begin
         rsp_tready <= 1'b1;
         hold_off = idle_len(rsp_steady);
      end
      if ($urandom_range(0, 199) == 0) rsp_steady = !rsp_steady;
   end

   task automatic send_word(input logic op, input logic [THRESH_BITS-1:0] raw,
                            input logic [TIME_BITS_DEFAULT-1:0] stamp);
      int gap;
      gap = idle_len(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_BITS'({stamp, raw});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic configure();
      write_reg(REG_RAIN_THRESHOLD, dirty(CSR_DATA_BITS'(plan.rain_threshold), THRESH_BITS));
      write_reg(REG_HOLD_POLLS, dirty(CSR_DATA_BITS'(plan.hold_polls), HOLD_BITS));
      write_reg(REG_REPORT_MODE, dirty(CSR_DATA_BITS'(plan.report_mode), MODE_BITS));
      write_reg(REG_REPORT_PERIOD_MS, plan.report_period_ms);
      write_reg(REG_IS_ONLINE, dirty(CSR_DATA_BITS'(plan.is_online), 1));
      write_reg(REG_OFFLINE_PERIOD_MS, plan.offline_period_ms);
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int phase;
      int phase_left;
      int run_left;
      int r;
      bit wet;
      logic [THRESH_BITS-1:0] raw;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: offline broadcast after 100 ms
      send_word(OP_READ, SAMPLE_FULL, 32'hFFFF_FFFF);
      send_word(OP_POLL, 10'd0, 32'd101);
      send_word(OP_POLL, SAMPLE_FULL, 32'd201);
      settle();

      // lowest threshold, no hold, report on change, short period clamped
      plan.rain_threshold = 10'd0;
      plan.hold_polls = 8'd0;
      plan.report_mode = MODE_ON_CHANGE;
      plan.report_period_ms = 32'd0;
      plan.is_online = 1'b1;
      plan.offline_period_ms = 32'd0;
      configure();
      send_word(OP_POLL, 10'd0, 32'd300);
      send_word(OP_POLL, SAMPLE_FULL - 10'd1, 32'd300);
      send_word(OP_POLL, SAMPLE_FULL, 32'd301);
      send_word(OP_READ, 10'd0, 32'd0);
      settle();

      // periodic reports across the time wrap
      plan.report_mode = MODE_PERIODIC;
      configure();
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'd10);
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'd11);
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'd21);
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'hFFFF_FFFF);
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'd9);
      send_word(OP_POLL, THRESH_BITS'($urandom), 32'd10);
      settle();

      plan.report_mode = MODE_UNUSED;
      configure();
      send_word(OP_POLL, 10'd0, 32'd1000);
      send_word(OP_POLL, SAMPLE_FULL, 32'd5000);
      settle();

      // highest threshold, offline with zero period
      plan.rain_threshold = SAMPLE_FULL;
      plan.hold_polls = 8'd1;
      plan.is_online = 1'b0;
      configure();
      send_word(OP_POLL, 10'd0, 32'd10);
      send_word(OP_POLL, 10'd0, 32'd10);
      send_word(OP_POLL, 10'd0, 32'd11);
      send_word(OP_READ, SAMPLE_FULL, 32'd11);

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         settle();
         r = $urandom_range(0, 9);
         plan.rain_threshold = (r == 0) ? 10'd0 : (r == 1) ? SAMPLE_FULL :
                               THRESH_BITS'($urandom_range(100, 900));
         r = $urandom_range(0, 99);
         if (r < 70) plan.hold_polls = HOLD_BITS'($urandom_range(0, 6));
         else if (r < 92) plan.hold_polls = HOLD_BITS'($urandom_range(7, 40));
         else if (r < 96) plan.hold_polls = 8'd254;
         else plan.hold_polls = 8'd255;
         plan.report_mode = MODE_BITS'($urandom_range(0, 3));
         r = $urandom_range(0, 99);
         if (r < 65) plan.report_period_ms = $urandom_range(10, 80);
         else if (r < 85) plan.report_period_ms = $urandom_range(0, 9);
         else if (r < 93) plan.report_period_ms = $urandom;
         else plan.report_period_ms = '1;
         plan.is_online = 1'($urandom_range(0, 1));
         r = $urandom_range(0, 99);
         if (r < 60) plan.offline_period_ms = $urandom_range(1, 80);
         else if (r < 80) plan.offline_period_ms = '0;
         else if (r < 90) plan.offline_period_ms = $urandom;
         else plan.offline_period_ms = '1;
         if (phase == 2) plan.hold_polls = 8'd255;
         if (phase == 5) plan.hold_polls = 8'd254;
         if (phase == 7) begin
            plan.report_period_ms = '1;
            plan.offline_period_ms = '1;
         end
         configure();

         phase_left = (plan.hold_polls > 100) ? 400 : 90;
         run_left = 0;
         while (phase_left > 0 && items_sent < RANDOM_ITEMS) begin
            if (items_sent % 50 == 0) req_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 85) wall_ms += $urandom_range(0, 12);
            else if (r < 95) wall_ms += $urandom_range(13, 300);
            else if (r < 98) wall_ms = $urandom;
            else wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
            // runs of one flag, mostly long enough to get through the debounce
            if (run_left == 0) begin
               wet = 1'($urandom_range(0, 1));
               r = $urandom_range(0, 99);
               run_left = (r < 65) ? plan.hold_polls + $urandom_range(1, 4) :
                          $urandom_range(1, plan.hold_polls + 1);
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_word(OP_READ, THRESH_BITS'($urandom), wall_ms);
            end else if (r < 16 && plan.hold_polls < 100) begin
               send_word(OP_POLL, THRESH_BITS'($urandom), wall_ms);
            end else begin
               if (wet && plan.rain_threshold != SAMPLE_FULL)
                  raw = THRESH_BITS'($urandom_range(0,
                                     SAMPLE_FULL - 10'd1 - plan.rain_threshold));
               else if (wet) raw = THRESH_BITS'($urandom);
               else raw = THRESH_BITS'($urandom_range(SAMPLE_FULL - plan.rain_threshold,
                                                      SAMPLE_FULL));
               send_word(OP_POLL, raw, wall_ms);
               run_left--;
            end
            phase_left--;
         end
         phase++;
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/rtdr_pkg.sv
hdl/rtdr_csr.sv
hdl/rtdr_engine.sv
hdl/rain_threshold_debounce_reporter_core.sv
tb/sv/rain_report_checker.sv
tb/sv/tb.sv
